// ===== src/rprt_pkg.sv =====
// Shared types and constants for the route pipe record table.
`default_nettype none

package rprt_pkg;

  localparam int ID_W = 12;
  localparam int OP_W = 2;

  // Operation codes carried on s_tuser.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_PURGE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TGT_RD,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS_WR,
    ST_PURGE_RD,
    ST_PURGE_CHK,
    ST_FILL,
    ST_FINISH
  } state_t;

  // Source and address of a table write.
  typedef enum logic [2:0] {
    WR_NONE,   // no write
    WR_NEW,    // updated record at idx
    WR_SHIFT,  // read word to idx-1
    WR_KEEP,   // read word to wptr
    WR_FILL    // held last word to wptr
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    idx_inc;
    logic    idx_set_one;
    logic    set_hit;
    logic    res_rd;
    logic    res_new;
    wr_sel_t wr_sel;
    logic    wptr_inc;
    logic    hold_cap;
    logic    purge_end;
    logic    used_inc;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            idx_at_used;
    logic            used_full;
    logic            id_match;
    logic            expired;
    logic            idx_last;
    logic            wptr_at_used;
    logic            fill_last;
    logic            out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/rprt_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none

module rprt_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/rprt_ctrl.sv =====
// Sequencing state machine for search, shift, compaction and result hand-off.
`default_nettype none

module rprt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rprt_pkg::stat_t stat,
  output rprt_pkg::cmd_t      cmd
);

  rprt_pkg::state_t state;
  rprt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rprt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rprt_pkg::ST_IDLE: begin
        if (in_valid) state_next = rprt_pkg::ST_DISPATCH;
      end
      rprt_pkg::ST_DISPATCH: begin
        if (stat.op == rprt_pkg::OP_INSERT || stat.op == rprt_pkg::OP_LOOKUP) begin
          state_next = rprt_pkg::ST_SCAN_RD;
        end else if (stat.op == rprt_pkg::OP_PURGE) begin
          state_next = rprt_pkg::ST_PURGE_RD;
        end else begin
          state_next = rprt_pkg::ST_FINISH;
        end
      end
      rprt_pkg::ST_SCAN_RD: begin
        if (!stat.idx_at_used) begin
          state_next = rprt_pkg::ST_SCAN_CHK;
        end else if (stat.op == rprt_pkg::OP_LOOKUP) begin
          state_next = rprt_pkg::ST_FINISH;
        end else if (stat.used_full) begin
          state_next = rprt_pkg::ST_SHIFT_RD;
        end else begin
          state_next = rprt_pkg::ST_TGT_RD;
        end
      end
      rprt_pkg::ST_SCAN_CHK: begin
        if (!stat.id_match) begin
          state_next = rprt_pkg::ST_SCAN_RD;
        end else if (stat.op == rprt_pkg::OP_LOOKUP) begin
          state_next = rprt_pkg::ST_FINISH;
        end else begin
          state_next = rprt_pkg::ST_INS_WR;
        end
      end
      rprt_pkg::ST_TGT_RD:   state_next = rprt_pkg::ST_INS_WR;
      rprt_pkg::ST_SHIFT_RD: state_next = rprt_pkg::ST_SHIFT_WR;
      rprt_pkg::ST_SHIFT_WR: begin
        state_next = stat.idx_last ? rprt_pkg::ST_INS_WR : rprt_pkg::ST_SHIFT_RD;
      end
      rprt_pkg::ST_INS_WR:   state_next = rprt_pkg::ST_FINISH;
      rprt_pkg::ST_PURGE_RD: begin
        if (!stat.idx_at_used) begin
          state_next = rprt_pkg::ST_PURGE_CHK;
        end else if (stat.wptr_at_used) begin
          state_next = rprt_pkg::ST_FINISH;
        end else begin
          state_next = rprt_pkg::ST_FILL;
        end
      end
      rprt_pkg::ST_PURGE_CHK: state_next = rprt_pkg::ST_PURGE_RD;
      rprt_pkg::ST_FILL: begin
        if (stat.fill_last) state_next = rprt_pkg::ST_FINISH;
      end
      rprt_pkg::ST_FINISH: begin
        if (stat.out_free) state_next = rprt_pkg::ST_IDLE;
      end
      default: state_next = rprt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.wr_sel = rprt_pkg::WR_NONE;
    unique case (state)
      rprt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rprt_pkg::ST_DISPATCH: begin
      end
      rprt_pkg::ST_SCAN_RD: begin
        if (!stat.idx_at_used) begin
          cmd.rd_en = 1'b1;
        end else if (stat.op != rprt_pkg::OP_LOOKUP && stat.used_full) begin
          cmd.idx_set_one = 1'b1;  // shift starts by moving slot 1 to slot 0
        end
      end
      rprt_pkg::ST_SCAN_CHK: begin
        if (stat.id_match) begin
          cmd.set_hit = 1'b1;
          cmd.res_rd  = (stat.op == rprt_pkg::OP_LOOKUP);
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      rprt_pkg::ST_TGT_RD,
      rprt_pkg::ST_SHIFT_RD: begin
        cmd.rd_en = 1'b1;
      end
      rprt_pkg::ST_SHIFT_WR: begin
        cmd.wr_sel  = rprt_pkg::WR_SHIFT;
        cmd.idx_inc = !stat.idx_last;
      end
      rprt_pkg::ST_INS_WR: begin
        cmd.wr_sel   = rprt_pkg::WR_NEW;
        cmd.res_new  = 1'b1;
        cmd.used_inc = !stat.hit && !stat.used_full;
      end
      rprt_pkg::ST_PURGE_RD: begin
        if (stat.idx_at_used) begin
          cmd.purge_end = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      rprt_pkg::ST_PURGE_CHK: begin
        cmd.hold_cap = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (!stat.expired) begin
          cmd.wr_sel   = rprt_pkg::WR_KEEP;
          cmd.wptr_inc = 1'b1;
        end
      end
      rprt_pkg::ST_FILL: begin
        cmd.wr_sel   = rprt_pkg::WR_FILL;
        cmd.wptr_inc = 1'b1;
      end
      rprt_pkg::ST_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rprt_dpath.sv =====
// Datapath: item register, pointers, record RAM, compare logic and output register.
`default_nettype none

module rprt_dpath #(
  parameter int TABLE_DEPTH = 16,
  parameter int REF_WIDTH   = 8,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int IN_W = rprt_pkg::ID_W + 2 + 3 * REF_WIDTH,
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W = 1 + AW + 3 + 2 * REF_WIDTH + 2 * CW,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rprt_pkg::cmd_t               cmd,
  output rprt_pkg::stat_t                   stat,
  input  wire logic [rprt_pkg::OP_W-1:0]    in_user,
  input  wire logic [IN_TDATA_W-1:0]        in_data,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic      [OUT_TDATA_W-1:0]       out_data
);

  typedef struct packed {
    logic [rprt_pkg::ID_W-1:0] id;
    logic                      two_way;
    logic                      endpoint;
    logic                      ep_uplink;
    logic [REF_WIDTH-1:0]      up;
    logic [REF_WIDTH-1:0]      down;
  } rec_t;

  localparam int REC_W = $bits(rec_t);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_DEPTH - 1);

  // item register
  logic [rprt_pkg::OP_W-1:0] op;
  logic [rprt_pkg::ID_W-1:0] id;
  logic                      tw;
  logic                      rcp;
  logic [REF_WIDTH-1:0]      up_in;
  logic [REF_WIDTH-1:0]      down_in;
  logic [REF_WIDTH-1:0]      exp_ref;

  logic [CW-1:0] used;
  logic [CW-1:0] idx;
  logic [CW-1:0] wptr;
  logic [CW-1:0] removed;
  logic          hit;
  rec_t          hold;

  rec_t          res_rec;
  logic          res_found;
  logic [AW-1:0] res_slot;

  logic [REC_W-1:0] rd_word;
  rec_t             rd_rec;
  rec_t             new_rec;
  logic [CW-1:0]    idx_m1;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  rec_t             wr_rec;
  logic [OUT_TDATA_W-1:0] out_pack;

  assign rd_rec = rec_t'(rd_word);
  assign idx_m1 = idx - CW'(1);

  // Updated record built from the old contents of its slot.
  always_comb begin
    new_rec           = rd_rec;
    new_rec.id        = id;
    new_rec.two_way   = tw;
    new_rec.endpoint  = tw & rcp;
    new_rec.ep_uplink = tw & rcp;
    if (tw) begin
      new_rec.up   = up_in;
      new_rec.down = rcp ? up_in : down_in;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx[AW-1:0];
    wr_rec  = rd_rec;
    unique case (cmd.wr_sel)
      rprt_pkg::WR_NONE:  wr_en = 1'b0;
      rprt_pkg::WR_NEW:   wr_rec = new_rec;
      rprt_pkg::WR_SHIFT: wr_addr = idx_m1[AW-1:0];
      rprt_pkg::WR_KEEP:  wr_addr = wptr[AW-1:0];
      rprt_pkg::WR_FILL: begin
        wr_addr = wptr[AW-1:0];
        wr_rec  = hold;
      end
      default: wr_en = 1'b0;
    endcase
  end

  rprt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (REC_W'(wr_rec)),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_word)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (cmd.set_hit) begin
        hit <= 1'b1;
      end
      if (cmd.used_inc) begin
        used <= used + CW'(1);
      end else if (cmd.purge_end) begin
        used <= wptr;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pointers and payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_user;
      id      <= in_data[rprt_pkg::ID_W-1:0];
      tw      <= in_data[rprt_pkg::ID_W];
      rcp     <= in_data[rprt_pkg::ID_W+1];
      up_in   <= in_data[rprt_pkg::ID_W+2 +: REF_WIDTH];
      down_in <= in_data[rprt_pkg::ID_W+2+REF_WIDTH +: REF_WIDTH];
      exp_ref <= in_data[rprt_pkg::ID_W+2+2*REF_WIDTH +: REF_WIDTH];
      idx     <= '0;
      wptr    <= '0;
      removed <= '0;
      res_rec <= '0;
      res_found <= 1'b0;
      res_slot  <= '0;
    end else begin
      if (cmd.idx_set_one) begin
        idx <= CW'(1);
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.wptr_inc) begin
        wptr <= wptr + CW'(1);
      end
      if (cmd.purge_end) begin
        removed <= used - wptr;
      end
      if (cmd.res_rd) begin
        res_rec   <= rd_rec;
        res_found <= 1'b1;
        res_slot  <= idx[AW-1:0];
      end else if (cmd.res_new) begin
        res_rec   <= new_rec;
        res_found <= hit;
        res_slot  <= idx[AW-1:0];
      end
    end
    if (cmd.hold_cap) begin
      hold <= rd_rec;
    end
    if (cmd.out_load) begin
      out_data <= out_pack;
    end
  end

  always_comb begin
    out_pack = '0;
    out_pack[OUT_W-1:0] = {removed, used, res_rec.down, res_rec.up, res_rec.two_way,
                           res_rec.ep_uplink, res_rec.endpoint, res_slot, res_found};
  end

  always_comb begin
    stat              = '0;
    stat.op           = op;
    stat.hit          = hit;
    stat.idx_at_used  = (idx == used);
    stat.used_full    = (used == FULL_CNT);
    stat.id_match     = (rd_rec.id == id);
    stat.expired      = (rd_rec.up == exp_ref) || (rd_rec.down == exp_ref);
    stat.idx_last     = (idx == LAST_IDX);
    stat.wptr_at_used = (wptr == used);
    stat.fill_last    = ((wptr + CW'(1)) == idx);
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== src/route_pipe_record_table_core.sv =====
// Top level of the route pipe record table: controller, datapath and checks.
`default_nettype none

// Packed table of up to TABLE_DEPTH routing-pipe records, oldest at slot 0,
// held in one RAM with registered read. One word in gives one result word.
// The block takes one word at a time; s_tready is high only while it is idle,
// and a finished result waits in the output register so the next word can be
// taken before the previous result is read. Timing is set by the single RAM
// read port, which serves one record at a time while walking the table.
// A lookup scans the used entries until a match or the end. An insert scans
// the same way, then updates a matching record in place or appends a new
// one after the last entry; when the table is full it first drops the
// oldest record by shifting every other record down one slot and writes the
// new one at the last slot. A purge compacts the records it keeps, then the
// freed tail slots are rewritten with the last old record. An unused opcode
// goes straight to the result. A result is loaded into the output register
// only while the previous one is gone or being read. A purge compares every
// record, including the one moved into a slot that was just vacated.
module route_pipe_record_table_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int REF_WIDTH   = 8,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int IN_W = rprt_pkg::ID_W + 2 + 3 * REF_WIDTH,
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W = 1 + AW + 3 + 2 * REF_WIDTH + 2 * CW,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input words
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // pipe_id, two_way, is_recipient, up_ref, down_ref, expired_ref, zero pad
  input  wire logic [IN_TDATA_W-1:0]     s_tdata,
  // opcode
  input  wire logic [rprt_pkg::OP_W-1:0] s_tuser,
  // result words
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // found, slot, endpoint, endpoint_uplink, two_way_out, next_up, next_down,
  // entries_used, removed_count, zero pad
  output logic      [OUT_TDATA_W-1:0]    m_tdata
);

  // Field offsets in the result word.
  localparam int OFS_USED = 1 + AW + 3 + 2 * REF_WIDTH;
  localparam int OFS_REM  = OFS_USED + CW;

  rprt_pkg::cmd_t  cmd;
  rprt_pkg::stat_t stat;

  rprt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rprt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .REF_WIDTH   (REF_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_user   (s_tuser),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

`ifndef NO_ASSERTIONS
  // One word in flight: the block stops taking words right after accepting one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("word accepted while another is in work");

  // Only a purge removes records, and a purge never reports a match.
  a_found_no_removal: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[OFS_REM +: CW] == '0))
    else $error("removed count set on a matched result");

  // Records left plus records removed never exceed the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (({1'b0, m_tdata[OFS_USED +: CW]} + {1'b0, m_tdata[OFS_REM +: CW]})
                  <= (CW + 1)'(TABLE_DEPTH)))
    else $error("entry count out of range");
`endif

endmodule

`default_nettype wire
